// ----- rtl/sbt_pkg.sv -----
package sbt_pkg;

    localparam int PIX_W     = 8;
    localparam int MAX_WIDTH = 2048;
    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int CW_W      = 12;
    localparam int H_W       = 16;
    localparam int TH_W      = 21;
    localparam int X_W       = 11;
    localparam int Y_W       = 16;
    localparam int GW        = 11;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int QSW    = QCW + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SQ = 2'd2;

    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;
    localparam int THRESH_RST = 10000;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    // one window column, index 0 = top row
    typedef logic [2:0][PIX_W-1:0] t_col;
    // three columns, index 0 = oldest
    typedef t_col [2:0] t_win;

    typedef struct packed {
        t_win           win;
        logic [AW-1:0]  col;
        logic [Y_W-1:0] row;
        logic           p0;
        logic           p1;
        logic           lc;
        logic           c_nz;
        logic           c_one;
        logic           y0;
        logic           r0;
    } t_job;

    typedef struct packed {
        logic           nonempty;
        logic [QCW-1:0] count;
    } t_qstat;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic           last;
    } t_rmeta;

endpackage

// ----- rtl/sbt_if.sv -----
interface sbt_pix_if import sbt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source(output valid, output pixel, input ready);
    modport sink(input valid, input pixel, output ready);
endinterface

interface sbt_res_if import sbt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_res;
    logic [X_W-1:0]   out_x;
    logic [Y_W-1:0]   out_y;
    logic             frame_last;

    modport source(output valid, output edge_res, output out_x, output out_y,
                   output frame_last, input ready);
    modport sink(input valid, input edge_res, input out_x, input out_y,
                 input frame_last, output ready);
endinterface

interface sbt_cfg_if import sbt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/sbt_ram.sv -----
module sbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/sbt_front.sv -----
module sbt_front import sbt_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [AW-1:0]  i_col_last,
    input  logic [Y_W-1:0] i_row_last,
    sbt_pix_if.sink        i_pix,
    input  t_qstat         i_qstat,
    output logic           o_push,
    output t_job           o_job
);

    logic             accept;
    logic             in_ready;
    logic [AW-1:0]    c;
    logic [Y_W-1:0]   r;
    logic             last_col;
    logic             last_row;
    logic [AW-1:0]    r_col, n_col;
    logic [Y_W-1:0]   r_row, n_row;
    logic [PIX_W-1:0] up_q, lo_q, up_eff, lo_eff;
    logic             r_b_v;
    logic [PIX_W-1:0] r_b_pix;
    logic [AW-1:0]    r_b_c;
    logic [Y_W-1:0]   r_b_r;
    logic             r_b_lc, r_b_lr;
    logic             r_fwd, n_fwd;
    logic [PIX_W-1:0] r_fwd_up, r_fwd_lo;
    t_win             r_win, n_win;

    // room for the item in flight plus this one
    assign in_ready    = (QSW'(i_qstat.count) + QSW'(r_b_v)) < QSW'(QDEPTH);
    assign i_pix.ready = in_ready;
    assign accept      = i_pix.valid && in_ready;

    always_comb begin
        c        = (r_col > i_col_last) ? i_col_last : r_col;
        r        = (r_row > i_row_last) ? i_row_last : r_row;
        last_col = (c == i_col_last);
        last_row = (r == i_row_last);
        n_col    = r_col;
        n_row    = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r + 1'b1;
            end else begin
                n_col = c + 1'b1;
                n_row = r;
            end
        end
        // same column read and written in one cycle
        n_fwd = accept && r_b_v && (r_b_c == c);
    end

    sbt_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk     (i_clk),
        .i_wr_en   (r_b_v),
        .i_wr_addr (r_b_c),
        .i_wr_data (lo_eff),
        .i_rd_en   (accept),
        .i_rd_addr (c),
        .o_rd_data (up_q)
    );

    sbt_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk     (i_clk),
        .i_wr_en   (r_b_v),
        .i_wr_addr (r_b_c),
        .i_wr_data (r_b_pix),
        .i_rd_en   (accept),
        .i_rd_addr (c),
        .o_rd_data (lo_q)
    );

    assign up_eff = r_fwd ? r_fwd_up : up_q;
    assign lo_eff = r_fwd ? r_fwd_lo : lo_q;

    always_comb begin
        n_win = r_win;
        if (r_b_v) begin
            n_win[0] = r_win[1];
            n_win[1] = r_win[2];
            n_win[2] = {r_b_pix, lo_eff, up_eff};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_b_v <= 1'b0;
            r_fwd <= 1'b0;
            r_win <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_b_v <= accept;
            r_fwd <= n_fwd;
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix  <= i_pix.pixel;
            r_b_c    <= c;
            r_b_r    <= r;
            r_b_lc   <= last_col;
            r_b_lr   <= last_row;
            r_fwd_up <= lo_eff;
            r_fwd_lo <= r_b_pix;
        end
    end

    assign o_push = r_b_v && ((r_b_r != '0) || r_b_lr) && ((r_b_c != '0) || r_b_lc);

    always_comb begin
        o_job       = '0;
        o_job.win   = n_win;
        o_job.col   = r_b_c;
        o_job.row   = r_b_r;
        o_job.r0    = (r_b_r == '0);
        o_job.p0    = (r_b_r != '0);
        o_job.y0    = (r_b_r == Y_W'(1));
        o_job.p1    = r_b_lr;
        o_job.lc    = r_b_lc;
        o_job.c_nz  = (r_b_c != '0);
        o_job.c_one = (r_b_c == AW'(1));
    end

    a_fwd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_b_v)
        else $error("line store bypass without an item in flight");

endmodule

// ----- rtl/sbt_queue.sv -----
module sbt_queue import sbt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_status
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_head, r_tail;
    logic [QCW-1:0] r_count;

    function automatic logic [QAW-1:0] wrap_inc(input logic [QAW-1:0] p);
        wrap_inc = (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= wrap_inc(r_tail);
            end
            if (i_pop) begin
                r_head <= wrap_inc(r_head);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_job;
        end
    end

    assign o_head            = r_mem[r_head];
    assign o_status.count    = r_count;
    assign o_status.nonempty = (r_count != '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCW'(QDEPTH)) || i_pop)
        else $error("window queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("window queue underflow");

endmodule

// ----- rtl/sbt_back.sv -----
module sbt_back import sbt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [TH_W-1:0] i_threshold_sq,
    input  t_job            i_head,
    input  t_qstat          i_qstat,
    output logic            o_pop,
    sbt_res_if.source       o_res
);

    t_job                   r_job;
    logic [3:0]             r_mask, n_mask;
    logic                   r_busy, n_busy;
    logic [3:0]             sel, rest, head_mask;
    logic                   issue, load;
    logic                   s1_rdy, s2_rdy, s3_rdy;
    logic                   pass1, atlast;
    logic [1:0]             rt, rm, rb;
    t_col                   lf, md, rg;
    logic signed [GW-1:0]   gx, gy;
    t_rmeta                 meta;
    logic                   r_s1_v, r_s2_v, r_s3_v;
    logic signed [GW-1:0]   r_s1_gx, r_s1_gy;
    t_rmeta                 r_s1_m, r_s2_m, r_s3_m;
    logic signed [2*GW-1:0] gx_p, gy_p;
    logic [TH_W-1:0]        r_s2_gx2, r_s2_gy2;
    logic [TH_W:0]          mag;
    logic [PIX_W-1:0]       r_s3_edge;

    function automatic logic signed [GW-1:0] ext(input logic [PIX_W-1:0] a);
        ext = $signed({{(GW - PIX_W){1'b0}}, a});
    endfunction

    assign s3_rdy = !r_s3_v || o_res.ready;
    assign s2_rdy = !r_s2_v || s3_rdy;
    assign s1_rdy = !r_s1_v || s2_rdy;

    // result order: row above at c-1, at c, then last row at c-1, at c
    assign head_mask = {i_head.p1 & i_head.lc, i_head.p1 & i_head.c_nz,
                        i_head.p0 & i_head.lc, i_head.p0 & i_head.c_nz};
    assign sel   = r_mask & (~r_mask + 1'b1);
    assign rest  = r_mask & ~sel;
    assign issue = r_busy && s1_rdy;
    assign load  = i_qstat.nonempty && (!r_busy || (issue && (rest == '0)));
    assign o_pop = load;

    always_comb begin
        n_busy = r_busy;
        n_mask = r_mask;
        if (load) begin
            n_busy = 1'b1;
            n_mask = head_mask;
        end else if (issue) begin
            n_busy = (rest != '0);
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mask <= '0;
        end else begin
            r_busy <= n_busy;
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_head;
        end
    end

    // window columns and rows with edge replication
    always_comb begin
        pass1  = sel[2] | sel[3];
        atlast = sel[1] | sel[3];
        if (pass1) begin
            rt = r_job.r0 ? 2'd2 : 2'd1;
            rm = 2'd2;
        end else begin
            rt = r_job.y0 ? 2'd1 : 2'd0;
            rm = 2'd1;
        end
        rb = 2'd2;
        if (atlast) begin
            lf = r_job.c_nz ? r_job.win[1] : r_job.win[2];
            md = r_job.win[2];
        end else begin
            lf = r_job.c_one ? r_job.win[1] : r_job.win[0];
            md = r_job.win[1];
        end
        rg = r_job.win[2];
        gx = (ext(rg[rt]) - ext(lf[rt])) + ((ext(rg[rm]) - ext(lf[rm])) <<< 1)
           + (ext(rg[rb]) - ext(lf[rb]));
        gy = (ext(lf[rb]) - ext(lf[rt])) + ((ext(md[rb]) - ext(md[rt])) <<< 1)
           + (ext(rg[rb]) - ext(rg[rt]));
        meta.x    = X_W'(atlast ? r_job.col : r_job.col - 1'b1);
        meta.y    = pass1 ? r_job.row : r_job.row - 1'b1;
        meta.last = pass1 & atlast;
    end

    assign gx_p = r_s1_gx * r_s1_gx;
    assign gy_p = r_s1_gy * r_s1_gy;
    assign mag  = {1'b0, r_s2_gx2} + {1'b0, r_s2_gy2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_v <= issue;
            end
            if (s2_rdy) begin
                r_s2_v <= r_s1_v;
            end
            if (s3_rdy) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_gx <= gx;
            r_s1_gy <= gy;
            r_s1_m  <= meta;
        end
        if (s2_rdy) begin
            r_s2_gx2 <= gx_p[TH_W-1:0];
            r_s2_gy2 <= gy_p[TH_W-1:0];
            r_s2_m   <= r_s1_m;
        end
        if (s3_rdy) begin
            r_s3_edge <= (mag > {1'b0, i_threshold_sq}) ? EDGE_ON : EDGE_OFF;
            r_s3_m    <= r_s2_m;
        end
    end

    assign o_res.valid      = r_s3_v;
    assign o_res.edge_res   = r_s3_edge;
    assign o_res.out_x      = r_s3_m.x;
    assign o_res.out_y      = r_s3_m.y;
    assign o_res.frame_last = r_s3_m.last;

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_mask != '0)
        else $error("result sequencer busy with nothing left to issue");

endmodule

// ----- rtl/sobel_edge_threshold.sv -----
// channel   dir   payload                               handshake
// i_pix     in    pixel[7:0]                            valid / ready
// o_res     out   edge_res[7:0] out_x out_y frame_last  valid / ready
// i_cfg     in    index[1:0] data[20:0]                 valid / ready (ready always high)
//
// one pixel per cycle while pixel ready is high; a pixel in the last column gives up to
// two results, a frame's last pixel up to four, one result leaves per cycle from the
// output stage while o_res ready is high; results pass the window queue, job register
// and gradient registers; rate is set by the single result port of the gradient pipeline
// reset sets width 640, height 480, threshold 10000 and the raster position
// to the frame start; line stores are not cleared, no clearing pass
// a stalled output fills a 4-entry window queue, then pixel ready drops
module sobel_edge_threshold import sbt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbt_cfg_if.sink   i_cfg,
    sbt_pix_if.sink   i_pix,
    sbt_res_if.source o_res
);

    logic [AW-1:0]   r_col_last;
    logic [Y_W-1:0]  r_row_last;
    logic [TH_W-1:0] r_thresh;
    logic [CW_W-1:0] cfg_w;
    logic [H_W-1:0]  cfg_h;
    logic [AW-1:0]   cfg_col_last;
    logic [Y_W-1:0]  cfg_row_last;
    logic            cfg_accept;
    logic            push, pop;
    t_job            push_job, head_job;
    t_qstat          qstat;

    assign i_cfg.ready = 1'b1;
    assign cfg_accept  = i_cfg.valid;

    // registers keep the last column and row index, clamped
    always_comb begin
        cfg_w = i_cfg.data[CW_W-1:0];
        cfg_h = i_cfg.data[H_W-1:0];
        if (cfg_w == '0) begin
            cfg_col_last = '0;
        end else if (cfg_w > CW_W'(MAX_WIDTH)) begin
            cfg_col_last = AW'(MAX_WIDTH - 1);
        end else begin
            cfg_col_last = AW'(cfg_w - 1'b1);
        end
        cfg_row_last = (cfg_h == '0) ? '0 : Y_W'(cfg_h - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= AW'(WIDTH_RST - 1);
            r_row_last <= Y_W'(HEIGHT_RST - 1);
            r_thresh   <= TH_W'(THRESH_RST);
        end else if (cfg_accept) begin
            unique case (i_cfg.index)
                CFG_IMAGE_WIDTH:  r_col_last <= cfg_col_last;
                CFG_IMAGE_HEIGHT: r_row_last <= cfg_row_last;
                CFG_THRESHOLD_SQ: r_thresh   <= i_cfg.data[TH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sbt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_col_last (r_col_last),
        .i_row_last (r_row_last),
        .i_pix      (i_pix),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (push_job)
    );

    sbt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (qstat)
    );

    sbt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_threshold_sq (r_thresh),
        .i_head         (head_job),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .o_res          (o_res)
    );

endmodule

// ----- test/sobel_edge_threshold_chk.sv -----
`timescale 1ns / 100ps

module sobel_edge_threshold_chk import sbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sbt_cfg_if   i_cfg,
    sbt_pix_if   i_pix,
    sbt_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [PIX_W-1:0] edge_val;
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic             last;
    } t_edge_rec;

    t_edge_rec        edge_q[$];
    logic [PIX_W-1:0] upper_row [MAX_WIDTH];
    logic [PIX_W-1:0] lower_row [MAX_WIDTH];
    t_win             win;
    int               width_reg;
    int               height_reg;
    int               thresh_reg;
    int               col_pos;
    int               row_pos;

    function automatic logic [PIX_W-1:0] grad_edge(input t_col lf, input t_col md,
                                                   input t_col rg, input int rt,
                                                   input int rm, input int rb);
        int gx;
        int gy;
        int mag;
        gx = (int'(rg[rt]) - int'(lf[rt])) + 2 * (int'(rg[rm]) - int'(lf[rm]))
           + (int'(rg[rb]) - int'(lf[rb]));
        gy = (int'(lf[rb]) - int'(lf[rt])) + 2 * (int'(md[rb]) - int'(md[rt]))
           + (int'(rg[rb]) - int'(rg[rt]));
        mag = gx * gx + gy * gy;
        return (mag > thresh_reg) ? EDGE_ON : EDGE_OFF;
    endfunction

    task automatic push_row_results(input int c, input int y, input int rt, input int rm,
                                    input int rb, input bit last_col, input bit fl);
        t_edge_rec rec;
        int        xm;
        if (c >= 1) begin
            xm = c - 1;
            rec.edge_val = grad_edge((c == 1) ? win[1] : win[0], win[1], win[2], rt, rm, rb);
            rec.x        = xm[X_W-1:0];
            rec.y        = y[Y_W-1:0];
            rec.last     = 1'b0;
            edge_q.push_back(rec);
        end
        if (last_col) begin
            rec.edge_val = grad_edge((c == 0) ? win[2] : win[1], win[2], win[2], rt, rm, rb);
            rec.x        = c[X_W-1:0];
            rec.y        = y[Y_W-1:0];
            rec.last     = fl;
            edge_q.push_back(rec);
        end
    endtask

    task automatic predict_pixel(input logic [PIX_W-1:0] p);
        int w;
        int h;
        int c;
        int r;
        bit last_col;
        bit last_row;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = height_reg;
        if (h < 1) h = 1;
        c = col_pos;
        r = row_pos;
        if (c > w - 1) c = w - 1;
        if (r > h - 1) r = h - 1;

        win[0]       = win[1];
        win[1]       = win[2];
        win[2][0]    = upper_row[c];
        win[2][1]    = lower_row[c];
        win[2][2]    = p;
        upper_row[c] = lower_row[c];
        lower_row[c] = p;

        last_col = (c == w - 1);
        last_row = (r == h - 1);
        // results of the row above
        if (r != 0) begin
            push_row_results(c, r - 1, (r == 1) ? 1 : 0, 1, 2, last_col, 1'b0);
        end
        // bottom row of the frame
        if (last_row) begin
            push_row_results(c, r, (r == 0) ? 2 : 1, 2, 2, last_col, 1'b1);
        end

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic check_result();
        t_edge_rec got;
        t_edge_rec want;
        got.edge_val = i_res.edge_res;
        got.x        = i_res.out_x;
        got.y        = i_res.out_y;
        got.last     = i_res.frame_last;
        if (edge_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("unexpected result: edge %0d x %0d y %0d last %0b",
                         got.edge_val, got.x, got.y, got.last);
            end
        end else begin
            want = edge_q.pop_front();
            if (got.edge_val !== want.edge_val || got.x !== want.x ||
                got.y !== want.y || got.last !== want.last) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display("mismatch edge/x/y/last: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                             want.edge_val, want.x, want.y, want.last,
                             got.edge_val, got.x, got.y, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg    = WIDTH_RST;
            height_reg   = HEIGHT_RST;
            thresh_reg   = THRESH_RST;
            win          = '0;
            col_pos      = 0;
            row_pos      = 0;
            o_fail_count = 0;
            edge_q.delete();
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_row[i] = '0;
                lower_row[i] = '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_IMAGE_WIDTH:  width_reg  = int'(i_cfg.data[CW_W-1:0]);
                    CFG_IMAGE_HEIGHT: height_reg = int'(i_cfg.data[H_W-1:0]);
                    CFG_THRESHOLD_SQ: thresh_reg = int'(i_cfg.data[TH_W-1:0]);
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                predict_pixel(i_pix.pixel);
            end
            if (i_res.valid && i_res.ready) begin
                check_result();
            end
        end
        o_pending = edge_q.size();
    end

endmodule

// ----- test/sobel_edge_threshold_tb.sv -----
`timescale 1ns / 100ps

module sobel_edge_threshold_tb;
    import sbt_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int LAT_PAUSE     = 12;
    localparam int RANDOM_PIXELS = 185;
    localparam int TH_MAX        = (1 << TH_W) - 1;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} t_rdy_mode;
    typedef enum logic [1:0] {PAT_NOISE, PAT_EXTREME, PAT_BARS, PAT_RAMP} t_pat;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    int          burst_left;
    bit          no_gaps;
    int          idle_cycles;
    t_rdy_mode   stall_mode;
    int          mode_left;
    int          sent;
    int          fw;
    int          fh;
    int          thr;
    int          bar;
    int          lo;
    int          hi;
    int          step;
    int          tmp;
    t_pat        pat;
    logic [7:0]  px;

    sbt_cfg_if cfg_if();
    sbt_pix_if pix_if();
    sbt_res_if res_if();

    sobel_edge_threshold u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    sobel_edge_threshold_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_if),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side stalls
    initial begin
        res_if.ready = 1'b0;
        mode_left    = 0;
        stall_mode   = RDY_ALWAYS;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                stall_mode = t_rdy_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(8, 80);
            end
            mode_left--;
            case (stall_mode)
                RDY_ALWAYS:   res_if.ready = 1'b1;
                RDY_MOSTLY:   res_if.ready = ($urandom_range(0, 3) != 0);
                RDY_RARELY:   res_if.ready = ($urandom_range(0, 3) == 0);
                default:      res_if.ready = (mode_left % 5 != 0);
            endcase
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_pixel(input logic [7:0] p);
        if (burst_left == 0) begin
            if (!no_gaps) begin
                pix_if.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        pix_if.valid = 1'b1;
        pix_if.pixel = p;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        pix_if.valid = 1'b0;
        burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (LAT_PAUSE) @(negedge i_clk);
    endtask

    task automatic set_frame(input int w, input int h, input int t);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_THRESHOLD_SQ, CFG_DATA_W'(t));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_IMAGE_WIDTH;
        cfg_if.data  = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        burst_left   = 0;
        no_gaps      = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset geometry, then narrowed in the middle of the first row
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);

        // zero width and height act as a single pixel
        set_frame(0, 0, 0);
        send_pixel(8'd255);

        // single column
        set_frame(1, 3, 0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd17);

        // vertical step right at the threshold
        set_frame(4, 3, 1040399);
        repeat (3) begin
            send_pixel(8'd0);
            send_pixel(8'd0);
            send_pixel(8'd255);
            send_pixel(8'd255);
        end

        // tallest frame, cut short by lowering the height mid-frame
        set_frame(2, 65535, 5000);
        repeat (9) send_pixel(8'($urandom_range(0, 255)));
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        send_pixel(8'($urandom_range(0, 255)));

        // oversized width clamps to the line store depth, then narrowed mid-row
        set_frame((1 << CW_W) - 1, 2, $urandom_range(0, 300000));
        no_gaps = 1'b1;
        repeat (8) send_pixel(8'($urandom_range(0, 255)));
        no_gaps = 1'b0;
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
        repeat (3) send_pixel(8'($urandom_range(0, 255)));

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            fw = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            fh = $urandom_range(1, 6);
            if (fw * fh > RANDOM_PIXELS - sent) begin
                fh = (RANDOM_PIXELS - sent) / fw;
                if (fh < 1) fh = 1;
            end
            case ($urandom_range(0, 5))
                0:       thr = 0;
                1:       thr = TH_MAX;
                2:       thr = $urandom_range(0, TH_MAX);
                default: thr = $urandom_range(0, 300000);
            endcase
            set_frame(fw, fh, thr);
            pat     = t_pat'($urandom_range(0, 3));
            no_gaps = ($urandom_range(0, 3) == 0);
            bar     = $urandom_range(1, 4);
            lo      = $urandom_range(0, 255);
            hi      = $urandom_range(0, 255);
            step    = $urandom_range(0, 64);
            for (int y = 0; y < fh; y++) begin
                for (int x = 0; x < fw; x++) begin
                    case (pat)
                        PAT_NOISE:   tmp = $urandom_range(0, 255);
                        PAT_EXTREME: tmp = $urandom_range(0, 1) ? 255 : 0;
                        PAT_BARS:    tmp = ((x / bar) % 2 == 1) ? hi : lo;
                        default:     tmp = x * step + y * (64 - step) + $urandom_range(0, 3);
                    endcase
                    px = tmp[7:0];
                    send_pixel(px);
                end
            end
            sent += fw * fh;
        end
        no_gaps = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sbt_pkg.sv
rtl/sbt_if.sv
rtl/sbt_ram.sv
rtl/sbt_front.sv
rtl/sbt_queue.sv
rtl/sbt_back.sv
rtl/sobel_edge_threshold.sv
test/sobel_edge_threshold_chk.sv
test/sobel_edge_threshold_tb.sv
